/* rtl/modexp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Operand width, word types and constants shared by the exponentiation block
// and its serial modular multiplier.
// ----------------------------------------------------------------------------
package modexp_pkg;

  // Width of base, exponent, modulus and result
  localparam int OPERAND_BITS = 31;
  // Step counter of the serial multiplier must hold OPERAND_BITS itself
  localparam int STEP_CNT_W   = $clog2(OPERAND_BITS + 1);

  typedef logic [OPERAND_BITS-1:0] operand_t;
  typedef logic [STEP_CNT_W-1:0]   step_cnt_t;

  localparam operand_t  OPER_ZERO  = '0;
  localparam operand_t  OPER_ONE   = OPERAND_BITS'(1);
  localparam step_cnt_t STEP_COUNT = STEP_CNT_W'(OPERAND_BITS);

  // Input word
  typedef struct packed {
    operand_t base_value;
    operand_t exponent_value;
    operand_t modulus_value;
  } operand_word_t;

  // Output word
  typedef struct packed {
    operand_t power_result;
    logic     bad_modulus;
  } result_word_t;

endpackage

/* rtl/modexp_mulser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial modular multiplier
// Computes a * b mod m for a < m, m nonzero, scanning b one bit per cycle
// from the MSB (double, conditionally add a, reduce). Once all OPERAND_BITS
// bits are done, done pulses for one cycle and product holds the result.
// ----------------------------------------------------------------------------
module modexp_mulser import modexp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  operand_t mul_a,
  input  operand_t mul_b,
  input  operand_t mul_m,
  output logic     done,
  output operand_t product
);

  localparam int SUM_W = OPERAND_BITS + 3;

  operand_t  acc;
  operand_t  mult;
  operand_t  modv;
  operand_t  bsr;
  step_cnt_t cnt;
  logic      busy;

  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] diff1;
  logic [SUM_W-1:0] diff2;
  operand_t         acc_next;

  // One step: sum = 2*acc + bit*a (< 3m), then subtract m or 2m
  always_comb begin
    sum   = {2'b00, acc, 1'b0} + (bsr[OPERAND_BITS-1] ? {3'b000, mult} : '0);
    diff1 = sum - {3'b000, modv};
    diff2 = sum - {2'b00, modv, 1'b0};
    if (!diff2[SUM_W-1]) begin
      acc_next = diff2[OPERAND_BITS-1:0];
    end else if (!diff1[SUM_W-1]) begin
      acc_next = diff1[OPERAND_BITS-1:0];
    end else begin
      acc_next = sum[OPERAND_BITS-1:0];
    end
  end

  // Control: step counter, busy and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= STEP_COUNT;
      end else if (busy) begin
        cnt <= cnt - step_cnt_t'(1);
        if (cnt == step_cnt_t'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: operand latch and shift register for b
  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= OPER_ZERO;
      mult <= mul_a;
      modv <= mul_m;
      bsr  <= mul_b;
    end else if (busy) begin
      acc <= acc_next;
      bsr <= {bsr[OPERAND_BITS-2:0], 1'b0};
    end
  end

  assign product = acc;

endmodule

/* rtl/modular_exponentiation_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation top level
// Right-to-left binary square-and-multiply: base^exponent mod modulus.
// ----------------------------------------------------------------------------
// One word at a time. A word with a zero modulus (flagged bad_modulus, result
// 0) or a zero exponent (result 1) goes straight to FINISH. Otherwise the base
// is first reduced mod modulus, then the multiplier runs a square for every
// exponent bit below the highest set bit and a multiply for every set bit;
// the result is then loaded into the output register. All multiplications
// share one bit-serial modular multiplier that handles one multiplier bit per
// cycle. The output register lets a new word be accepted while the previous
// result is still stalled.
// ----------------------------------------------------------------------------
module modular_exponentiation_top import modexp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          operand_valid,
  output logic          operand_stall,
  input  operand_word_t operand,
  output logic          result_valid,
  input  logic          result_stall,
  output result_word_t  result
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_REDUCE = 5'b00010,
    S_MULR   = 5'b00100,
    S_SQR    = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t   state;
  state_t   state_next;
  operand_t xv;
  operand_t xv_next;
  operand_t nv;
  operand_t nv_next;
  operand_t mv;
  operand_t mv_next;
  operand_t res;
  operand_t res_next;
  logic     bad;
  logic     bad_next;

  logic     mul_start;
  operand_t mul_a;
  operand_t mul_b;
  operand_t mul_m;
  logic     mul_done;
  operand_t mul_p;
  operand_t n_shift;
  operand_t res_init;
  logic     in_take;
  logic     out_load;

  assign in_take  = operand_valid && !operand_stall;
  assign out_load = (state == S_FINISH) && (!result_valid || !result_stall);
  assign n_shift  = {1'b0, nv[OPERAND_BITS-1:1]};
  // 1 mod m for the running result
  assign res_init = (mv == OPER_ONE) ? OPER_ZERO : OPER_ONE;

  modexp_mulser u_mulser (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mul_a   (mul_a),
    .mul_b   (mul_b),
    .mul_m   (mul_m),
    .done    (mul_done),
    .product (mul_p)
  );

  // Sequencer: picks the next multiplication as soon as one finishes
  always_comb begin
    state_next = state;
    xv_next    = xv;
    nv_next    = nv;
    mv_next    = mv;
    res_next   = res;
    bad_next   = bad;
    mul_start  = 1'b0;
    mul_a      = xv;
    mul_b      = xv;
    mul_m      = mv;
    unique case (state)
      S_IDLE: begin
        if (in_take) begin
          xv_next  = operand.base_value;
          nv_next  = operand.exponent_value;
          mv_next  = operand.modulus_value;
          bad_next = 1'b0;
          if (operand.modulus_value == OPER_ZERO) begin
            res_next   = OPER_ZERO;
            bad_next   = 1'b1;
            state_next = S_FINISH;
          end else if (operand.exponent_value == OPER_ZERO) begin
            res_next   = OPER_ONE;
            state_next = S_FINISH;
          end else begin
            // base mod m as 1 * base mod m
            mul_start  = 1'b1;
            mul_a      = OPER_ONE;
            mul_b      = operand.base_value;
            mul_m      = operand.modulus_value;
            state_next = S_REDUCE;
          end
        end
      end
      S_REDUCE: begin
        if (mul_done) begin
          xv_next   = mul_p;
          res_next  = res_init;
          mul_start = 1'b1;
          if (nv[0]) begin
            mul_a      = res_init;
            mul_b      = mul_p;
            state_next = S_MULR;
          end else begin
            mul_a      = mul_p;
            mul_b      = mul_p;
            state_next = S_SQR;
          end
        end
      end
      S_MULR: begin
        if (mul_done) begin
          res_next = mul_p;
          if (n_shift == OPER_ZERO) begin
            state_next = S_FINISH;
          end else begin
            mul_start  = 1'b1;
            state_next = S_SQR;
          end
        end
      end
      S_SQR: begin
        // n_shift is nonzero here, so another multiplication always follows
        if (mul_done) begin
          xv_next   = mul_p;
          nv_next   = n_shift;
          mul_start = 1'b1;
          if (n_shift[0]) begin
            mul_a      = res;
            mul_b      = mul_p;
            state_next = S_MULR;
          end else begin
            mul_a      = mul_p;
            mul_b      = mul_p;
            state_next = S_SQR;
          end
        end
      end
      S_FINISH: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Working registers and output word
  always_ff @(posedge clk) begin
    xv  <= xv_next;
    nv  <= nv_next;
    mv  <= mv_next;
    res <= res_next;
    bad <= bad_next;
    if (out_load) begin
      result.power_result <= res;
      result.bad_modulus  <= bad;
    end
  end

  assign operand_stall = (state != S_IDLE);

  // A flagged modulus always comes with a zero result
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.bad_modulus |-> result.power_result == OPER_ZERO)
    else $error("bad_modulus set with nonzero power_result");

  // The multiplier only finishes while the sequencer waits for it
  assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_REDUCE || state == S_MULR || state == S_SQR))
    else $error("multiplier done outside a multiply state");

  // Leaving FINISH always presents a result
  assert property (@(posedge clk) disable iff (rst)
    out_load |=> result_valid && state == S_IDLE)
    else $error("finished word not presented on the result channel");

  // No multiplication starts while a result waits for the output register
  assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !(state == S_FINISH))
    else $error("multiplication started in FINISH");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation testbench
// Walks a short table of directed words (zero modulus, zero exponent, modulus
// of one, operand extremes), then random words of mixed operand widths. The
// expected result of each accepted word comes from the table where it is
// obvious, else from a square-and-multiply predictor. The operand side idles
// and the result side stalls at random.
// ----------------------------------------------------------------------------
module tb_top;
  import modexp_pkg::*;

  localparam operand_t    OPER_MAX     = '1;
  localparam int          RANDOM_WORDS = 266;
  localparam int          DRAIN_CYCLES = 64;
  localparam int unsigned CYCLE_LIMIT  = 3000000;

  typedef struct {
    operand_word_t word;
    bit            typed;
    result_word_t  res;
  } directed_row_t;

  logic          clk           = 1'b0;
  logic          rst           = 1'b1;
  logic          operand_valid = 1'b0;
  logic          operand_stall;
  operand_word_t operand       = '0;
  logic          result_valid;
  logic          result_stall  = 1'b0;
  result_word_t  result;

  result_word_t  expected_results[$];
  directed_row_t directed_rows[$];
  int unsigned   error_count = 0;
  int unsigned   cycle_cnt   = 0;
  int unsigned   stall_cnt   = 0;
  bit            idle_on     = 1'b1;

  modular_exponentiation_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .operand_valid (operand_valid),
    .operand_stall (operand_stall),
    .operand       (operand),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result)
  );

  // 8 ns clock
  initial begin
    forever #4 clk = ~clk;
  end

  // Square-and-multiply over all exponent bits, LSB first
  function automatic result_word_t predict_power(operand_word_t w);
    result_word_t                r;
    logic [2*OPERAND_BITS-1:0]   prod;
    operand_t                    acc;
    operand_t                    sq;
    r.bad_modulus = 1'b0;
    if (w.modulus_value == OPER_ZERO) begin
      r.power_result = OPER_ZERO;
      r.bad_modulus  = 1'b1;
      return r;
    end
    // acc stays an unreduced 1 when the exponent is zero
    acc = OPER_ONE;
    sq  = w.base_value % w.modulus_value;
    for (int i = 0; i < OPERAND_BITS; i++) begin
      if (w.exponent_value[i]) begin
        prod = acc * sq;
        acc  = operand_t'(prod % w.modulus_value);
      end
      prod = sq * sq;
      sq   = operand_t'(prod % w.modulus_value);
    end
    r.power_result = acc;
    return r;
  endfunction

  // Idle length: mostly none or short, a few long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Random operand of random bit length
  function automatic operand_t rand_narrow();
    int unsigned w;
    w = $urandom_range(1, OPERAND_BITS);
    return operand_t'($urandom) >> (OPERAND_BITS - w);
  endfunction

  function automatic operand_word_t rand_word();
    operand_word_t w;
    int unsigned   sel;
    sel = $urandom_range(0, 19);
    case (sel)
      0:       w.modulus_value = OPER_ZERO;
      1:       w.modulus_value = OPER_ONE;
      2:       w.modulus_value = OPER_MAX;
      3, 4, 5, 6, 7, 8, 9: w.modulus_value = operand_t'($urandom);
      default: w.modulus_value = rand_narrow();
    endcase
    sel = $urandom_range(0, 19);
    case (sel)
      0:       w.base_value = OPER_ZERO;
      1:       w.base_value = OPER_ONE;
      2:       w.base_value = OPER_MAX;
      3:       w.base_value = w.modulus_value - OPER_ONE;
      4, 5, 6, 7, 8, 9, 10, 11: w.base_value = operand_t'($urandom);
      default: w.base_value = rand_narrow();
    endcase
    sel = $urandom_range(0, 19);
    case (sel)
      0:       w.exponent_value = OPER_ZERO;
      1:       w.exponent_value = OPER_MAX;
      2, 3, 4, 5, 6, 7, 8, 9, 10, 11: w.exponent_value = operand_t'($urandom);
      default: w.exponent_value = rand_narrow();
    endcase
    return w;
  endfunction

  task automatic add_row(input operand_t b, input operand_t e, input operand_t m,
                         input bit typed, input operand_t pwr, input logic bad);
    directed_row_t row;
    row.word.base_value     = b;
    row.word.exponent_value = e;
    row.word.modulus_value  = m;
    row.typed               = typed;
    row.res.power_result    = pwr;
    row.res.bad_modulus     = bad;
    directed_rows.push_back(row);
  endtask

  // Present one word, hold it through stalls, then record its result
  task automatic drive_operands(input operand_word_t w, input result_word_t res);
    int unsigned gap;
    operand       <= w;
    operand_valid <= 1'b1;
    do @(posedge clk); while (operand_stall);
    expected_results.push_back(res);
    gap = idle_len();
    if (gap != 0) begin
      operand_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stimulus
  initial begin
    operand_word_t w;
    // zero modulus
    add_row(31'd5,      31'd3,      OPER_ZERO,  1'b1, OPER_ZERO,  1'b1);
    add_row(OPER_ZERO,  OPER_ZERO,  OPER_ZERO,  1'b1, OPER_ZERO,  1'b1);
    add_row(OPER_MAX,   OPER_MAX,   OPER_ZERO,  1'b1, OPER_ZERO,  1'b1);
    // zero exponent, modulus of one included
    add_row(31'd7,      OPER_ZERO,  OPER_ONE,   1'b1, OPER_ONE,   1'b0);
    add_row(OPER_MAX,   OPER_ZERO,  OPER_MAX,   1'b1, OPER_ONE,   1'b0);
    add_row(OPER_ZERO,  OPER_ZERO,  31'd13,     1'b1, OPER_ONE,   1'b0);
    // modulus of one with a nonzero exponent, then other small and extreme words
    add_row(OPER_MAX,   31'd5,      OPER_ONE,   1'b1, OPER_ZERO,  1'b0);
    add_row(OPER_ZERO,  OPER_ONE,   OPER_MAX,   1'b1, OPER_ZERO,  1'b0);
    add_row(OPER_ONE,   OPER_MAX,   OPER_MAX,   1'b1, OPER_ONE,   1'b0);
    add_row(31'd2,      31'd10,     31'd1000,   1'b1, 31'd24,     1'b0);
    add_row(31'd3,      31'd4,      31'd100,    1'b1, 31'd81,     1'b0);
    add_row(OPER_MAX,   OPER_ONE,   OPER_MAX,   1'b1, OPER_ZERO,  1'b0);
    add_row(OPER_MAX,   OPER_MAX,   OPER_MAX,   1'b1, OPER_ZERO,  1'b0);
    // base above modulus is reduced first, then powers of two mod OPER_MAX
    add_row(31'd12,     OPER_ONE,   31'd5,      1'b1, 31'd2,      1'b0);
    add_row(31'd2,      31'd30,     OPER_MAX,   1'b1, 31'h40000000, 1'b0);
    add_row(31'd2,      31'd31,     OPER_MAX,   1'b1, OPER_ONE,   1'b0);
    // predicted rows
    add_row(OPER_MAX,   OPER_ONE,   31'd12345,  1'b0, OPER_ZERO,  1'b0);
    add_row(OPER_MAX,   OPER_MAX,   OPER_MAX - OPER_ONE, 1'b0, OPER_ZERO, 1'b0);
    add_row(OPER_MAX,   OPER_MAX,   31'h40000001, 1'b0, OPER_ZERO, 1'b0);
    add_row(31'h40000000, 31'd2,    OPER_MAX,   1'b0, OPER_ZERO,  1'b0);
    add_row(OPER_MAX - OPER_ONE, 31'd2, OPER_MAX, 1'b0, OPER_ZERO, 1'b0);
    add_row(31'd123456789, 31'd987654321, 31'd1000000007, 1'b0, OPER_ZERO, 1'b0);
    add_row(31'h2AAAAAAA, 31'h55555555, 31'h2AAAAAAA, 1'b0, OPER_ZERO, 1'b0);
    add_row(31'h55555555, 31'h2AAAAAAA, 31'h55555555, 1'b0, OPER_ZERO, 1'b0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      drive_operands(directed_rows[i].word,
                     directed_rows[i].typed ? directed_rows[i].res
                                            : predict_power(directed_rows[i].word));
    end

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // alternate stretches with and without idling
      if (n % 20 == 0) idle_on = ($urandom_range(0, 3) != 0);
      w = rand_word();
      drive_operands(w, predict_power(w));
    end
    operand_valid <= 1'b0;

    // drain
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Random result stall
  always @(posedge clk) begin
    if (stall_cnt != 0) begin
      result_stall <= 1'b1;
      stall_cnt    <= stall_cnt - 1;
    end else begin
      result_stall <= 1'b0;
      stall_cnt    <= idle_len();
    end
  end

  // Result checker
  always @(posedge clk) begin
    result_word_t exp_res;
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result word: power_result %0d bad_modulus %0b",
                 $time, result.power_result, result.bad_modulus);
        error_count++;
      end else begin
        exp_res = expected_results.pop_front();
        if (result.power_result !== exp_res.power_result) begin
          $display("%0t: power_result expected %0d got %0d",
                   $time, exp_res.power_result, result.power_result);
          error_count++;
        end
        if (result.bad_modulus !== exp_res.bad_modulus) begin
          $display("%0t: bad_modulus expected %0b got %0b",
                   $time, exp_res.bad_modulus, result.bad_modulus);
          error_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule

/* files.f */
rtl/modexp_pkg.sv
rtl/modexp_mulser.sv
rtl/modular_exponentiation_top.sv
test/tb_top.sv
